FILE: src/miu_pkg.sv
// miu_pkg: shared types, opcodes and helpers of the mips64 integer execute unit
// no dependencies
`default_nettype none
package miu_pkg;
  localparam int XLEN      = 64;
  localparam int GPR_DEPTH = 32;
  localparam int RIDX_W    = $clog2(GPR_DEPTH);

  // major opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;

  // special function codes
  localparam logic [5:0] FN_MFHI   = 6'h10;
  localparam logic [5:0] FN_MTHI   = 6'h11;
  localparam logic [5:0] FN_MFLO   = 6'h12;
  localparam logic [5:0] FN_MTLO   = 6'h13;
  localparam logic [5:0] FN_DSLLV  = 6'h14;
  localparam logic [5:0] FN_DSRLV  = 6'h16;
  localparam logic [5:0] FN_DSRAV  = 6'h17;
  localparam logic [5:0] FN_MULT   = 6'h18;
  localparam logic [5:0] FN_MULTU  = 6'h19;
  localparam logic [5:0] FN_DIV    = 6'h1A;
  localparam logic [5:0] FN_DIVU   = 6'h1B;
  localparam logic [5:0] FN_DDIV   = 6'h1E;
  localparam logic [5:0] FN_DDIVU  = 6'h1F;
  localparam logic [5:0] FN_ADD    = 6'h20;
  localparam logic [5:0] FN_ADDU   = 6'h21;
  localparam logic [5:0] FN_SUB    = 6'h22;
  localparam logic [5:0] FN_SUBU   = 6'h23;
  localparam logic [5:0] FN_AND    = 6'h24;
  localparam logic [5:0] FN_OR     = 6'h25;
  localparam logic [5:0] FN_XOR    = 6'h26;
  localparam logic [5:0] FN_NOR    = 6'h27;
  localparam logic [5:0] FN_SLT    = 6'h2A;
  localparam logic [5:0] FN_SLTU   = 6'h2B;
  localparam logic [5:0] FN_DADD   = 6'h2C;
  localparam logic [5:0] FN_DADDU  = 6'h2D;
  localparam logic [5:0] FN_DSUB   = 6'h2E;
  localparam logic [5:0] FN_DSUBU  = 6'h2F;
  localparam logic [5:0] FN_DSLL   = 6'h38;
  localparam logic [5:0] FN_DSRL   = 6'h3A;
  localparam logic [5:0] FN_DSRA   = 6'h3B;
  localparam logic [5:0] FN_DSLL32 = 6'h3C;
  localparam logic [5:0] FN_DSRL32 = 6'h3E;
  localparam logic [5:0] FN_DSRA32 = 6'h3F;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_EXEC, S_MUL, S_DIV, S_DIVFIX, S_DONE
  } state_t;

  typedef struct packed {
    logic             reg_written;
    logic [4:0]       dest_index;
    logic [XLEN-1:0]  dest_value;
    logic [XLEN-1:0]  hi_value;
    logic [XLEN-1:0]  lo_value;
    logic             unsupported;
  } result_t;

  function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
    return {{(XLEN-32){v[31]}}, v[31:0]};
  endfunction
endpackage
`default_nettype wire

FILE: src/miu_if.sv
// miu_cmd_if, miu_rsp_if: valid/ready channels of the execute unit
// depends on miu_pkg
`default_nettype none
interface miu_cmd_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface miu_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     reg_written;
  logic [4:0]               dest_index;
  logic [miu_pkg::XLEN-1:0] dest_value;
  logic [miu_pkg::XLEN-1:0] hi_value;
  logic [miu_pkg::XLEN-1:0] lo_value;
  logic                     unsupported;
  modport source (output valid, output reg_written, output dest_index, output dest_value,
                  output hi_value, output lo_value, output unsupported, input ready);
  modport sink   (input valid, input reg_written, input dest_index, input dest_value,
                  input hi_value, input lo_value, input unsupported, output ready);
endinterface
`default_nettype wire

FILE: src/mips64_integer_execute_unit.sv
// mips64_integer_execute_unit: top level, decode, alu, multiply and divide
// depends on miu_pkg, miu_if, miu_ram
// states: S_LOAD, S_EXEC (alu, hi/lo moves), S_MUL (multiplies), S_DIV and S_DIVFIX (divides),
//   S_DONE; S_DIV gives one quotient bit per cycle over 64 steps; a divide by zero skips S_DIV and S_DIVFIX
// throughput: one request at a time; the next is taken once the result is in the output register
// reset: synchronous, clears control state, the hi/lo pair and the register valid bits,
//   so every general register reads zero after reset
`default_nettype none
module mips64_integer_execute_unit (
  input wire logic clk,
  input wire logic rst,
  miu_cmd_if.sink   cmd,
  miu_rsp_if.source rsp
);
  import miu_pkg::*;

  state_t state, state_next;

  // request and operands
  logic [31:0]       ir;
  logic [XLEN-1:0]   opa, opb;
  logic [XLEN-1:0]   rdata_a, rdata_b;
  logic [GPR_DEPTH-1:0] gpr_vld;

  // architectural hi/lo
  logic [XLEN-1:0]   hi, lo;

  // pending result
  logic              res_wr;
  logic [RIDX_W-1:0] res_dst;
  logic [XLEN-1:0]   res_val;
  logic              res_unsup;

  // multiplier and divider
  logic [XLEN-1:0]   prod;
  logic [XLEN-1:0]   dv_rem, dv_quo, dv_den;
  logic              dv_negq, dv_negr, dv_is32;
  logic [5:0]        dv_cnt;

  // output register
  logic              out_valid;
  result_t           out_res;

  logic [5:0] op, fn;
  logic [RIDX_W-1:0] rs, rt, rd, sa;
  assign op = ir[31:26];
  assign fn = ir[5:0];
  assign rs = ir[25:21];
  assign rt = ir[20:16];
  assign rd = ir[15:11];
  assign sa = ir[10:6];

  logic accept, out_load, gpr_we;
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);
  assign gpr_we    = out_load && res_wr;

  // two copies of the register file, one per read port, written together
  miu_ram #(.WIDTH(XLEN), .DEPTH(GPR_DEPTH)) u_gpr_a (
    .clk(clk), .we(gpr_we), .waddr(res_dst), .wdata(res_val),
    .re(accept), .raddr(cmd.instruction[25:21]), .rdata(rdata_a)
  );
  miu_ram #(.WIDTH(XLEN), .DEPTH(GPR_DEPTH)) u_gpr_b (
    .clk(clk), .we(gpr_we), .waddr(res_dst), .wdata(res_val),
    .re(accept), .raddr(cmd.instruction[20:16]), .rdata(rdata_b)
  );

  // decode and alu
  logic            e_wr, e_unsup, e_mthi, e_mtlo, e_mul, e_div;
  logic [XLEN-1:0] e_val, imm;
  logic [5:0]      sh_var, sh_32;
  assign imm    = {{(XLEN-16){1'b0}}, ir[15:0]};
  assign sh_var = opa[5:0];
  assign sh_32  = {1'b1, sa};

  always_comb begin
    e_wr = 1'b1; e_unsup = 1'b0; e_mthi = 1'b0; e_mtlo = 1'b0;
    e_mul = 1'b0; e_div = 1'b0; e_val = '0;
    if (op == OP_SPECIAL) begin
      case (fn)
        FN_MFHI: e_val = hi;
        FN_MFLO: e_val = lo;
        FN_MTHI: begin e_wr = 1'b0; e_mthi = 1'b1; end
        FN_MTLO: begin e_wr = 1'b0; e_mtlo = 1'b1; end
        FN_DSLLV: e_val = opb << sh_var;
        FN_DSRLV: e_val = opb >> sh_var;
        FN_DSRAV: e_val = $signed(opb) >>> sh_var;
        FN_MULT, FN_MULTU: begin e_wr = 1'b0; e_mul = 1'b1; end
        FN_DIV, FN_DIVU, FN_DDIV, FN_DDIVU: begin e_wr = 1'b0; e_div = 1'b1; end
        FN_ADD, FN_ADDU: e_val = sext32(opa + opb);
        FN_SUB, FN_SUBU: e_val = sext32(opa - opb);
        FN_AND:  e_val = opa & opb;
        FN_OR:   e_val = opa | opb;
        FN_XOR:  e_val = opa ^ opb;
        FN_NOR:  e_val = ~(opa | opb);
        FN_SLT:  e_val = {{(XLEN-1){1'b0}}, $signed(opa) < $signed(opb)};
        FN_SLTU: e_val = {{(XLEN-1){1'b0}}, opa < opb};
        FN_DADD, FN_DADDU: e_val = opa + opb;
        FN_DSUB, FN_DSUBU: e_val = opa - opb;
        FN_DSLL:   e_val = opb << sa;
        FN_DSRL:   e_val = opb >> sa;
        FN_DSRA:   e_val = $signed(opb) >>> sa;
        FN_DSLL32: e_val = opb << sh_32;
        FN_DSRL32: e_val = opb >> sh_32;
        FN_DSRA32: e_val = $signed(opb) >>> sh_32;
        default: begin e_wr = 1'b0; e_unsup = 1'b1; end
      endcase
    end else begin
      case (op)
        OP_ANDI: e_val = opa & imm;
        OP_ORI:  e_val = opa | imm;
        OP_XORI: e_val = opa ^ imm;
        OP_LUI:  e_val = sext32({imm[XLEN-17:0], 16'h0000});
        default: begin e_wr = 1'b0; e_unsup = 1'b1; end
      endcase
    end
  end

  logic [RIDX_W-1:0] e_dst;
  assign e_dst = (op == OP_SPECIAL) ? rd : rt;

  // multiply operands: 33-bit signed covers both signed and unsigned forms
  logic            mul_sgn;
  logic [32:0]     mul_a, mul_b;
  logic [65:0]     mul_p;
  assign mul_sgn = (fn == FN_MULT);
  assign mul_a   = {mul_sgn & opa[31], opa[31:0]};
  assign mul_b   = {mul_sgn & opb[31], opb[31:0]};
  assign mul_p   = 66'($signed(mul_a) * $signed(mul_b));

  // divide setup
  logic            d_32, d_sgn, d_na, d_nb, d_zero;
  logic [XLEN-1:0] d_a, d_b;
  assign d_32   = (fn == FN_DIV) || (fn == FN_DIVU);
  assign d_sgn  = (fn == FN_DIV) || (fn == FN_DDIV);
  assign d_a    = d_32 ? (d_sgn ? sext32(opa) : {32'h0, opa[31:0]}) : opa;
  assign d_b    = d_32 ? (d_sgn ? sext32(opb) : {32'h0, opb[31:0]}) : opb;
  assign d_na   = d_sgn && d_a[XLEN-1];
  assign d_nb   = d_sgn && d_b[XLEN-1];
  assign d_zero = (d_b == '0);

  // restoring divide step, one quotient bit per cycle
  // two guard bits: the shifted remainder can exceed 64 bits for wide unsigned divisors
  logic [XLEN+1:0] dv_trial;
  assign dv_trial = {1'b0, dv_rem, dv_quo[XLEN-1]} - {2'b00, dv_den};

  logic [XLEN-1:0] fix_q, fix_r;
  assign fix_q = dv_negq ? (0 - dv_quo) : dv_quo;
  assign fix_r = dv_negr ? (0 - dv_rem) : dv_rem;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_LOAD;
      S_LOAD:   state_next = S_EXEC;
      S_EXEC: begin
        if (e_mul)                state_next = S_MUL;
        else if (e_div && !d_zero) state_next = S_DIV;
        else                      state_next = S_DONE;
      end
      S_MUL:    state_next = S_DONE;
      S_DIV:    if (dv_cnt == 6'd63) state_next = S_DIVFIX;
      S_DIVFIX: state_next = S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control: valid bits, hi/lo, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      gpr_vld   <= '0;
      hi        <= '0;
      lo        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (gpr_we) begin
        gpr_vld[res_dst] <= 1'b1;
      end
      if (state == S_EXEC && e_mthi) begin
        hi <= opa;
      end
      if (state == S_EXEC && e_mtlo) begin
        lo <= opa;
      end
      if (state == S_MUL) begin
        hi <= sext32({32'h0, prod[63:32]});
        lo <= sext32(prod);
      end
      if (state == S_DIVFIX) begin
        hi <= dv_is32 ? sext32(fix_r) : fix_r;
        lo <= dv_is32 ? sext32(fix_q) : fix_q;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      ir <= cmd.instruction;
    end
    if (state == S_LOAD) begin
      opa <= gpr_vld[rs] ? rdata_a : '0;
      opb <= gpr_vld[rt] ? rdata_b : '0;
    end
    if (state == S_EXEC) begin
      res_wr    <= e_wr && (e_dst != '0);
      res_dst   <= (e_wr && (e_dst != '0)) ? e_dst : '0;
      res_val   <= (e_wr && (e_dst != '0)) ? e_val : '0;
      res_unsup <= e_unsup;
      prod      <= mul_p[XLEN-1:0];
      dv_rem    <= '0;
      dv_quo    <= d_na ? (0 - d_a) : d_a;
      dv_den    <= d_nb ? (0 - d_b) : d_b;
      dv_negq   <= d_na ^ d_nb;
      dv_negr   <= d_na;
      dv_is32   <= d_32;
      dv_cnt    <= '0;
    end
    if (state == S_DIV) begin
      dv_cnt <= dv_cnt + 6'd1;
      if (!dv_trial[XLEN+1]) begin
        dv_rem <= dv_trial[XLEN-1:0];
        dv_quo <= {dv_quo[XLEN-2:0], 1'b1};
      end else begin
        dv_rem <= {dv_rem[XLEN-2:0], dv_quo[XLEN-1]};
        dv_quo <= {dv_quo[XLEN-2:0], 1'b0};
      end
    end
    if (out_load) begin
      out_res.reg_written <= res_wr;
      out_res.dest_index  <= res_dst;
      out_res.dest_value  <= res_val;
      out_res.hi_value    <= hi;
      out_res.lo_value    <= lo;
      out_res.unsupported <= res_unsup;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.reg_written = out_res.reg_written;
  assign rsp.dest_index  = out_res.dest_index;
  assign rsp.dest_value  = out_res.dest_value;
  assign rsp.hi_value    = out_res.hi_value;
  assign rsp.lo_value    = out_res.lo_value;
  assign rsp.unsupported = out_res.unsupported;
endmodule
`default_nettype wire

FILE: src/miu_ram.sv
// miu_ram: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none
module miu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire
